// ===== rtl/skw_pkg.sv =====
// Shared types and constants for the session keepalive watchdog.
// No dependencies; imported by skw_tick_alu and session_keepalive_watchdog_top.
`timescale 1ns / 1ps

package skw_pkg;

   // Session table geometry and timing constants.
   localparam int SESSIONS   = 16;
   localparam int SESS_W     = $clog2(SESSIONS);
   localparam int COUNT_W    = SESS_W + 1;
   localparam int FLIGHT_W   = 8;
   localparam int WAIT_W     = 32;
   localparam int TIMEOUT_W  = 16;
   localparam int TICK_MS    = 5;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam logic [FLIGHT_W-1:0]  COUNT_MAX    = 8'd255;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd1000;
   localparam logic [TIMEOUT_W-1:0] PING_FLOOR   = TIMEOUT_W'(3 * TICK_MS);
   localparam logic [TIMEOUT_W-1:0] ABORT_FLOOR  = TIMEOUT_W'(6 * TICK_MS);

   // Event kinds carried on the request channel.
   typedef enum logic [1:0] {
      KIND_START     = 2'd0,
      KIND_FINISH    = 2'd1,
      KIND_TICK      = 2'd2,
      KIND_PING_DONE = 2'd3
   } kind_type;

   // Result actions.
   typedef enum logic {
      ACT_PING  = 1'b0,
      ACT_ABORT = 1'b1
   } action_type;

   // Per-session keepalive ping state.
   typedef enum logic [1:0] {
      PING_NONE = 2'd0,
      PING_SENT = 2'd1,
      PING_DONE = 2'd2
   } ping_state_type;

   // Result of one step of the shared tick unit.
   typedef struct packed {
      logic [WAIT_W-1:0] wait_ms;
      logic              hit;
      action_type        action;
   } alu_result_type;

endpackage

// ===== rtl/session_keepalive_watchdog_top.sv =====
// Top level of the session keepalive watchdog: session tables, sequencer, ports.
// Depends on skw_pkg and skw_tick_alu.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  req_     | in        | tuser: kind; tdata: session
//  rsp_     | out       | tuser: action; tdata: session, waited_ms; tlast
//  csr_     | in        | wdata: timeout_ms
//
// A start, ping-completed or non-emptying finish item is handled in the idle
// state; a finish that empties its session also takes the swap-with-last step.
// A tick sets thresholds, passes each list entry through the shared tick unit,
// closes the walk and retires completed pings, and then releases the held final
// result.
// A stalled result port holds the walk at the entry that has a result to hand on.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module session_keepalive_watchdog_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [skw_pkg::REQ_DATA_W-1:0]    req_tdata,   // [3:0] session
   input  logic [skw_pkg::REQ_USER_W-1:0]    req_tuser,   // [1:0] kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [skw_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [3:0] session, [35:4] waited_ms
   output logic                              rsp_tuser,   // [0] action
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [skw_pkg::TIMEOUT_W-1:0]     csr_wdata
);
   import skw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWAP,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Session tables.
   logic [SESS_W-1:0]   active_list_ff   [SESSIONS];
   logic [SESS_W-1:0]   list_pos_ff      [SESSIONS];
   logic [FLIGHT_W-1:0] in_flight_ff     [SESSIONS];
   logic [WAIT_W-1:0]   wait_ff          [SESSIONS];
   ping_state_type      ping_ff          [SESSIONS];

   // Control and result registers.
   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    idx_ff, idx_in;
   logic [SESS_W-1:0]     victim_ff, victim_in;
   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [TIMEOUT_W-1:0]  ping_ms_ff, ping_ms_in;
   logic [TIMEOUT_W-1:0]  abort_ms_ff, abort_ms_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SESS_W-1:0]     pend_sess_ff, pend_sess_in;
   action_type            pend_act_ff, pend_act_in;
   logic [WAIT_W-1:0]     pend_wait_ff, pend_wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SESS_W-1:0]     rsp_sess_ff, rsp_sess_in;
   action_type            rsp_act_ff, rsp_act_in;
   logic [WAIT_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Table write ports.
   logic                  list_we;
   logic [SESS_W-1:0]     list_waddr, list_wdata;
   logic                  pos_we;
   logic [SESS_W-1:0]     pos_waddr, pos_wdata;
   logic                  flight_we;
   logic [SESS_W-1:0]     flight_waddr;
   logic [FLIGHT_W-1:0]   flight_wdata;
   logic                  wait_we;
   logic [SESS_W-1:0]     wait_waddr;
   logic [WAIT_W-1:0]     wait_wdata;
   logic                  ping_we;
   logic [SESS_W-1:0]     ping_waddr;
   ping_state_type        ping_wdata;
   logic                  ping_retire;

   // Datapath signals.
   logic [SESS_W-1:0]     list_raddr, list_rdata;
   logic [SESS_W-1:0]     req_sess;
   kind_type              req_kind;
   logic                  out_free;
   logic [TIMEOUT_W-1:0]  half_ms;
   alu_result_type        alu_res;

   assign req_sess   = req_tdata[SESS_W-1:0];
   assign req_kind   = kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign half_ms    = timeout_ff >> 1;

   // Single read port of the active list: walk entry or list tail.
   assign list_raddr = (state_ff == ST_SWAP) ? SESS_W'(count_ff - COUNT_W'(1))
                                             : idx_ff[SESS_W-1:0];
   assign list_rdata = active_list_ff[list_raddr];

   skw_tick_alu u_alu (
      .wait_ms    (wait_ff[list_rdata]),
      .ping_state (ping_ff[list_rdata]),
      .ping_ms    (ping_ms_ff),
      .abort_ms   (abort_ms_ff),
      .result     (alu_res)
   );

   // Sequencer next-state and table write control.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      victim_in     = victim_ff;
      ping_ms_in    = ping_ms_ff;
      abort_ms_in   = abort_ms_ff;
      pend_valid_in = pend_valid_ff;
      pend_sess_in  = pend_sess_ff;
      pend_act_in   = pend_act_ff;
      pend_wait_in  = pend_wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sess_in   = rsp_sess_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_last_in   = rsp_last_ff;
      list_we       = 1'b0;
      list_waddr    = count_ff[SESS_W-1:0];
      list_wdata    = req_sess;
      pos_we        = 1'b0;
      pos_waddr     = req_sess;
      pos_wdata     = count_ff[SESS_W-1:0];
      flight_we     = 1'b0;
      flight_waddr  = req_sess;
      flight_wdata  = in_flight_ff[req_sess];
      wait_we       = 1'b0;
      wait_waddr    = req_sess;
      wait_wdata    = '0;
      ping_we       = 1'b0;
      ping_waddr    = req_sess;
      ping_wdata    = PING_DONE;
      ping_retire   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  KIND_START: begin
                     if (in_flight_ff[req_sess] != COUNT_MAX) begin
                        flight_we    = 1'b1;
                        flight_wdata = in_flight_ff[req_sess] + FLIGHT_W'(1);
                        // First request of an idle session appends it to the list.
                        if (in_flight_ff[req_sess] == '0) begin
                           list_we  = 1'b1;
                           pos_we   = 1'b1;
                           count_in = count_ff + COUNT_W'(1);
                        end
                     end
                  end
                  KIND_FINISH: begin
                     if (in_flight_ff[req_sess] != '0) begin
                        flight_we    = 1'b1;
                        flight_wdata = in_flight_ff[req_sess] - FLIGHT_W'(1);
                        wait_we      = 1'b1;
                        if (in_flight_ff[req_sess] == FLIGHT_W'(1)) begin
                           victim_in = req_sess;
                           state_in  = ST_SWAP;
                        end
                     end
                  end
                  KIND_TICK: begin
                     // Latch thresholds for this walk.
                     if (half_ms < PING_FLOOR) begin
                        ping_ms_in  = PING_FLOOR;
                        abort_ms_in = ABORT_FLOOR;
                     end else begin
                        ping_ms_in  = half_ms;
                        abort_ms_in = timeout_ff;
                     end
                     idx_in   = '0;
                     state_in = ST_WALK;
                  end
                  KIND_PING_DONE: begin
                     if (ping_ff[req_sess] == PING_SENT) begin
                        ping_we = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SWAP: begin
            // Move the list tail into the departing session's slot.
            list_we    = 1'b1;
            list_waddr = list_pos_ff[victim_ff];
            list_wdata = list_rdata;
            pos_we     = 1'b1;
            pos_waddr  = list_rdata;
            pos_wdata  = list_pos_ff[victim_ff];
            count_in   = count_ff - COUNT_W'(1);
            state_in   = ST_IDLE;
         end

         ST_WALK: begin
            if (idx_ff == count_ff) begin
               ping_retire = 1'b1;
               state_in    = ST_FLUSH;
            end else if (!(alu_res.hit && pend_valid_ff && !out_free)) begin
               wait_we    = 1'b1;
               wait_waddr = list_rdata;
               wait_wdata = alu_res.wait_ms;
               if (alu_res.hit) begin
                  if (alu_res.action == ACT_PING) begin
                     ping_we    = 1'b1;
                     ping_waddr = list_rdata;
                     ping_wdata = PING_SENT;
                  end
                  // Hand the held result on; it is not the final one.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sess_in  = pend_sess_ff;
                     rsp_act_in   = pend_act_ff;
                     rsp_wait_in  = pend_wait_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_sess_in  = list_rdata;
                  pend_act_in   = alu_res.action;
                  pend_wait_in  = alu_res.wait_ms;
               end
               idx_in = idx_ff + COUNT_W'(1);
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sess_in   = pend_sess_ff;
               rsp_act_in    = pend_act_ff;
               rsp_wait_in   = pend_wait_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         timeout_ff    <= TIMEOUT_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            timeout_ff <= csr_wdata;
         end
      end
      idx_ff       <= idx_in;
      victim_ff    <= victim_in;
      ping_ms_ff   <= ping_ms_in;
      abort_ms_ff  <= abort_ms_in;
      pend_sess_ff <= pend_sess_in;
      pend_act_ff  <= pend_act_in;
      pend_wait_ff <= pend_wait_in;
      rsp_sess_ff  <= rsp_sess_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Active list and list positions hold no reset value.
   always_ff @(posedge clock) begin
      if (list_we) begin
         active_list_ff[list_waddr] <= list_wdata;
      end
      if (pos_we) begin
         list_pos_ff[pos_waddr] <= pos_wdata;
      end
   end

   // Per-session counters, wait times and ping states.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SESSIONS; i++) begin
            in_flight_ff[i] <= '0;
            wait_ff[i]      <= '0;
            ping_ff[i]      <= PING_NONE;
         end
      end else begin
         if (flight_we) begin
            in_flight_ff[flight_waddr] <= flight_wdata;
         end
         if (wait_we) begin
            wait_ff[wait_waddr] <= wait_wdata;
         end
         if (ping_retire) begin
            for (int i = 0; i < SESSIONS; i++) begin
               if (ping_ff[i] == PING_DONE) begin
                  ping_ff[i] <= PING_NONE;
               end
            end
         end else if (ping_we) begin
            ping_ff[ping_waddr] <= ping_wdata;
         end
      end
   end

   // Result port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - WAIT_W - SESS_W)'(0), rsp_wait_ff, rsp_sess_ff};
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/skw_tick_alu.sv =====
// Shared tick unit: saturating wait-time increment and threshold compare.
// Depends on skw_pkg; instantiated once by session_keepalive_watchdog_top.
`timescale 1ns / 1ps

module skw_tick_alu (
   input  logic [skw_pkg::WAIT_W-1:0]    wait_ms,
   input  skw_pkg::ping_state_type       ping_state,
   input  logic [skw_pkg::TIMEOUT_W-1:0] ping_ms,
   input  logic [skw_pkg::TIMEOUT_W-1:0] abort_ms,
   output skw_pkg::alu_result_type       result
);
   import skw_pkg::*;

   logic [WAIT_W:0]   sum;
   logic [WAIT_W-1:0] grown;

   // Add one tick and saturate on carry out.
   assign sum   = {1'b0, wait_ms} + (WAIT_W + 1)'(TICK_MS);
   assign grown = sum[WAIT_W] ? {WAIT_W{1'b1}} : sum[WAIT_W-1:0];

   // Classify the grown wait time against the two thresholds.
   always_comb begin
      result.wait_ms = grown;
      result.hit     = 1'b0;
      result.action  = ACT_PING;
      if (grown < WAIT_W'(ping_ms)) begin
         result.hit = 1'b0;
      end else if (grown > WAIT_W'(abort_ms)) begin
         result.hit    = 1'b1;
         result.action = ACT_ABORT;
      end else if (ping_state == PING_NONE) begin
         result.hit    = 1'b1;
         result.action = ACT_PING;
      end
   end

endmodule

// ===== sim/session_keepalive_watchdog_top_tb.sv =====
// Self-checking testbench for session_keepalive_watchdog_top: a tracker class predicts
// the ping and abort items of every tick and checks them in order.
// Depends on skw_pkg and the RTL of session_keepalive_watchdog_top.
`timescale 1ns / 1ps

module session_keepalive_watchdog_top_tb;
   import skw_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 24;
   localparam int HOLD_CYCLES = 300;

   // One expected ping or abort item.
   typedef struct {
      logic [SESS_W-1:0] session;
      action_type        action;
      logic [WAIT_W-1:0] waited_ms;
      logic              last;
   } alarm_type;

   // Tracks the session tables and holds the alarms still due from the block.
   class watchdog_tracker;
      logic [TIMEOUT_W-1:0] timeout_ms;
      logic [SESS_W-1:0]    order[SESSIONS];
      int unsigned          slot_of[SESSIONS];
      int unsigned          live;
      logic [FLIGHT_W-1:0]  open_reqs[SESSIONS];
      logic [WAIT_W-1:0]    idle_ms[SESSIONS];
      ping_state_type       ping_st[SESSIONS];
      alarm_type            alarms_due[$];
      int                   failures;
      int                   reported;
      int                   predicted;

      function new();
         timeout_ms = TIMEOUT_RST;
         live = 0;
         failures = 0;
         reported = 0;
         predicted = 0;
         foreach (order[x]) begin
            order[x] = '0;
            slot_of[x] = 0;
            open_reqs[x] = '0;
            idle_ms[x] = '0;
            ping_st[x] = PING_NONE;
         end
      endfunction

      function void set_timeout(logic [TIMEOUT_W-1:0] value);
         timeout_ms = value;
      endfunction

      // Update the tables for one accepted item and queue the alarms it raises.
      function void accept_event(kind_type kind, logic [SESS_W-1:0] s);
         alarm_type         batch[$];
         alarm_type         one;
         int unsigned       ping_at;
         int unsigned       abort_at;
         int unsigned       pos;
         logic [SESS_W-1:0] a;
         logic [SESS_W-1:0] tail;
         logic [WAIT_W:0]   sum;
         logic [WAIT_W-1:0] w;
         case (kind)
            KIND_TICK: begin
               ping_at = timeout_ms / 2;
               abort_at = timeout_ms;
               if (ping_at < 3 * TICK_MS) begin
                  ping_at = 3 * TICK_MS;
                  abort_at = 2 * ping_at;
               end
               for (int i = 0; i < live; i++) begin
                  a = order[i];
                  sum = {1'b0, idle_ms[a]} + (WAIT_W + 1)'(TICK_MS);
                  w = sum[WAIT_W] ? '1 : sum[WAIT_W-1:0];
                  idle_ms[a] = w;
                  if (w >= ping_at) begin
                     one.session = a;
                     one.waited_ms = w;
                     one.last = 1'b0;
                     // Aborts repeat on every tick; a ping goes out only while the ping state is none.
                     if (w > abort_at) begin
                        one.action = ACT_ABORT;
                        batch = {batch, one};
                     end else if (ping_st[a] == PING_NONE) begin
                        ping_st[a] = PING_SENT;
                        one.action = ACT_PING;
                        batch = {batch, one};
                     end
                  end
               end
               // Completed pings retire only after the walk.
               foreach (ping_st[x])
                  if (ping_st[x] == PING_DONE)
                     ping_st[x] = PING_NONE;
               if (batch.size() > 0)
                  batch[batch.size() - 1].last = 1'b1;
               foreach (batch[j])
                  alarms_due = {alarms_due, batch[j]};
               predicted += batch.size();
            end
            KIND_START: begin
               if (open_reqs[s] < COUNT_MAX) begin
                  open_reqs[s]++;
                  if (open_reqs[s] == 1 && live < SESSIONS) begin
                     slot_of[s] = live;
                     order[live] = s;
                     live++;
                  end
               end
            end
            KIND_FINISH: begin
               // A finish at zero count is dropped and keeps the wait time.
               if (open_reqs[s] != 0) begin
                  open_reqs[s]--;
                  if (open_reqs[s] == 0 && live > 0) begin
                     pos = slot_of[s];
                     tail = order[live - 1];
                     if (pos < live) begin
                        order[pos] = tail;
                        slot_of[tail] = pos;
                     end
                     live--;
                  end
                  idle_ms[s] = '0;
               end
            end
            KIND_PING_DONE: begin
               if (ping_st[s] == PING_SENT)
                  ping_st[s] = PING_DONE;
            end
         endcase
      endfunction

      // Compare one item from the result port with the oldest alarm due.
      function void match_alarm(logic [SESS_W-1:0] session, logic action,
                                logic [WAIT_W-1:0] waited, logic last);
         alarm_type want;
         if (alarms_due.size() == 0) begin
            failures++;
            if (reported < 10)
               $display("ERROR: unexpected item session %0d action %0d waited %0d last %0b",
                        session, action, waited, last);
            reported++;
            return;
         end
         want = alarms_due.pop_front();
         if (want.session !== session || want.action !== action ||
             want.waited_ms !== waited || want.last !== last) begin
            failures++;
            if (reported < 10)
               $display("ERROR: want s%0d a%0d w%0d l%0b, got s%0d a%0d w%0d l%0b",
                        want.session, want.action, want.waited_ms, want.last,
                        session, action, waited, last);
            reported++;
         end
      endfunction

      function void close_out();
         if (alarms_due.size() > 0) begin
            failures += alarms_due.size();
            $display("ERROR: %0d expected items never arrived", alarms_due.size());
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata;   // [3:0] session
   logic [REQ_USER_W-1:0]    req_tuser;   // [1:0] kind
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;   // [3:0] session, [35:4] waited_ms
   logic                     rsp_tuser;   // [0] action
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [TIMEOUT_W-1:0]     csr_wdata;

   watchdog_tracker board;
   bit sender_gaps;
   bit rsp_stalls;
   int hold_off_left;

   session_keepalive_watchdog_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result port: random stalls, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else if (!rsp_stalls) begin
            rsp_tready <= 1'b1;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
               stall_left = gap_length();
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Check every accepted result item.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.match_alarm(rsp_tdata[SESS_W-1:0], rsp_tuser,
                           rsp_tdata[SESS_W+WAIT_W-1:SESS_W], rsp_tlast);

   // Offer one item from a falling edge until it is taken; returns at a falling edge.
   task automatic send_event(kind_type kind, logic [SESS_W-1:0] s);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= REQ_DATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.accept_event(kind, s);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      int n;
      n = sender_gaps ? gap_length() : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Stop sending, let every due alarm arrive, then let a silent tick finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.alarms_due.size() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_timeout(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SESS_W-1:0] pick_session(kind_type kind);
      logic [SESS_W-1:0] waiting[$];
      // Finishes mostly hit live sessions, completions mostly outstanding pings.
      if (kind == KIND_FINISH && board.live > 0 && $urandom_range(0, 9) < 8)
         return board.order[$urandom_range(0, board.live - 1)];
      if (kind == KIND_PING_DONE && $urandom_range(0, 9) < 8) begin
         foreach (board.ping_st[x])
            if (board.ping_st[x] == PING_SENT)
               waiting = {waiting, SESS_W'(x)};
         if (waiting.size() > 0)
            return waiting[$urandom_range(0, waiting.size() - 1)];
      end
      return SESS_W'($urandom_range(0, SESSIONS - 1));
   endfunction

   task automatic run_random(logic [TIMEOUT_W-1:0] timeout, int count, bit gaps, bit stalls);
      kind_type kind;
      int       r;
      wait_idle();
      write_timeout(timeout);
      sender_gaps = gaps;
      rsp_stalls = stalls;
      repeat (count) begin
         r = $urandom_range(0, 99);
         kind = r < 30 ? KIND_START : r < 50 ? KIND_FINISH : r < 82 ? KIND_TICK : KIND_PING_DONE;
         send_event(kind, pick_session(kind));
         idle_sender();
      end
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] phase_timeouts[8];
      board = new();
      phase_timeouts = '{16'hFFFF, 16'd40, 16'd1, 16'd100, 16'd0, 16'd25, 16'd62, 16'd1000};
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      sender_gaps = 1'b0;
      rsp_stalls = 1'b1;
      hold_off_left = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: floored thresholds, ping 15 and abort 30.
      write_timeout(16'd0);
      send_event(KIND_START, 4'd0);
      send_event(KIND_START, 4'd15);
      send_event(KIND_START, 4'd0);
      send_event(KIND_TICK, 4'd0);
      // Completion with no ping outstanding, finish at zero count.
      send_event(KIND_PING_DONE, 4'd0);
      send_event(KIND_FINISH, 4'd7);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_TICK, 4'd15);
      send_event(KIND_PING_DONE, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_FINISH, 4'd0);
      send_event(KIND_FINISH, 4'd15);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_START, 4'd3);
      send_event(KIND_START, 4'd9);
      // Removing the head moves the tail into its slot.
      send_event(KIND_FINISH, 4'd0);
      send_event(KIND_TICK, 4'd0);
      send_event(KIND_FINISH, 4'd9);
      send_event(KIND_FINISH, 4'd3);
      // Empty list: a tick with no items.
      send_event(KIND_TICK, 4'd0);

      // Hold the result port while ticks keep coming, so the block backs up.
      wait_idle();
      write_timeout(16'd0);
      for (int i = 1; i <= 8; i++)
         send_event(KIND_START, SESS_W'(i));
      hold_off_left = HOLD_CYCLES;
      repeat (24) send_event(KIND_TICK, 4'd0);

      foreach (phase_timeouts[p])
         run_random(phase_timeouts[p], 18, p % 3 != 1, p % 4 != 2);

      wait_idle();
      board.close_out();
      if (board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
